[design/vrf_pkg.sv]
package vrf_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_WIDTH  = 16;
    localparam int OUT_WIDTH = 20;

    localparam int MW     = 48;
    localparam int EI_W   = 18;
    localparam int D_W    = 19;
    localparam int E2_W   = 19;
    localparam int OM_W   = 23;
    localparam int K_W    = 27;
    localparam int ED_W   = 21;
    localparam int F_W    = 22;
    localparam int V_W    = 24;
    localparam int RAD_W  = 40;
    localparam int ROOT_W = RAD_W / 2;

    localparam logic signed [MW-1:0] ONE  = 48'sd1 <<< FRAC_BITS;
    localparam logic        [MW-1:0] HALF = 48'd1 << (FRAC_BITS - 1);

    localparam logic signed [V_W-1:0] V_MAX = V_W'((2 ** (OUT_WIDTH - 1)) - 1);
    localparam logic signed [V_W-1:0] V_MIN = -V_MAX - V_W'(1);

    localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = OUT_WIDTH'((2 ** (OUT_WIDTH - 1)) - 1);
    localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = -OUT_MAX - OUT_WIDTH'(1);

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] incident_x;
        logic signed [IN_WIDTH-1:0] incident_y;
        logic signed [IN_WIDTH-1:0] incident_z;
        logic signed [IN_WIDTH-1:0] normal_x;
        logic signed [IN_WIDTH-1:0] normal_y;
        logic signed [IN_WIDTH-1:0] normal_z;
        logic        [IN_WIDTH-1:0] index_ratio;
    } vrf_in_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] refracted_x;
        logic signed [OUT_WIDTH-1:0] refracted_y;
        logic signed [OUT_WIDTH-1:0] refracted_z;
        logic                        total_reflection;
        logic                        saturated;
    } vrf_out_t;

    typedef struct packed {
        logic signed [ED_W-1:0]     ed;
        logic signed [EI_W-1:0]     ei_x;
        logic signed [EI_W-1:0]     ei_y;
        logic signed [EI_W-1:0]     ei_z;
        logic signed [IN_WIDTH-1:0] nv_x;
        logic signed [IN_WIDTH-1:0] nv_y;
        logic signed [IN_WIDTH-1:0] nv_z;
        logic                       tir;
    } vrf_side_t;

    // Shift a product right by the fraction bits, rounding half away from zero.
    function automatic logic signed [MW-1:0] rnd(input logic signed [MW-1:0] p);
        logic [MW-1:0] mag;
        logic [MW-1:0] q;
        mag = p[MW-1] ? MW'(-p) : MW'(p);
        q   = (mag + HALF) >> FRAC_BITS;
        rnd = p[MW-1] ? -$signed(q) : $signed(q);
    endfunction

endpackage

[design/vec3_refract_core.sv]
// Channel  | Dir | Handshake               | Word
// ray      | in  | ray_valid / ray_ready   | vrf_in_t: incident, normal, index ratio
// res      | out | res_valid / res_ready   | vrf_out_t: refracted vector and flags
//
// One word is taken every cycle while the skid register is empty; a ray passes stages s1 to s6,
// the 20-stage bit-per-stage square root between the k and f stages, s27, s28, then the output register.
// Reset clears every stage valid bit and the output and skid valid bits.
// The whole pipeline advances together and holds while the output skid register is full.
module vec3_refract_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             ray_valid,
    output logic             ray_ready,
    input  vrf_pkg::vrf_in_t ray,
    output logic             res_valid,
    input  logic             res_ready,
    output vrf_pkg::vrf_out_t res
);
    import vrf_pkg::*;

    localparam int SIDE_W = $bits(vrf_side_t);

    logic en;

    logic signed [IN_WIDTH-1:0] iv [3];
    logic signed [IN_WIDTH-1:0] nv [3];
    logic signed [IN_WIDTH:0]   eta;

    logic                       s1_valid_reg;
    logic signed [31:0]         s1_dp_reg [3];
    logic signed [33:0]         s1_e2_reg;
    logic signed [32:0]         s1_ei_reg [3];
    logic signed [IN_WIDTH-1:0] s1_nv_reg [3];
    logic signed [IN_WIDTH:0]   s1_eta_reg;

    logic                       s2_valid_reg;
    logic signed [D_W-1:0]      s2_d_reg;
    logic signed [E2_W-1:0]     s2_e2_reg;
    logic signed [EI_W-1:0]     s2_ei_reg [3];
    logic signed [IN_WIDTH-1:0] s2_nv_reg [3];
    logic signed [IN_WIDTH:0]   s2_eta_reg;
    logic signed [D_W-1:0]      s2_d_next;

    logic                       s3_valid_reg;
    logic signed [37:0]         s3_dd_reg;
    logic signed [35:0]         s3_ed_reg;
    logic signed [E2_W-1:0]     s3_e2_reg;
    logic signed [EI_W-1:0]     s3_ei_reg [3];
    logic signed [IN_WIDTH-1:0] s3_nv_reg [3];

    logic                       s4_valid_reg;
    logic signed [OM_W-1:0]     s4_om_reg;
    logic signed [ED_W-1:0]     s4_ed_reg;
    logic signed [E2_W-1:0]     s4_e2_reg;
    logic signed [EI_W-1:0]     s4_ei_reg [3];
    logic signed [IN_WIDTH-1:0] s4_nv_reg [3];

    logic                       s5_valid_reg;
    logic signed [41:0]         s5_pk_reg;
    logic signed [ED_W-1:0]     s5_ed_reg;
    logic signed [EI_W-1:0]     s5_ei_reg [3];
    logic signed [IN_WIDTH-1:0] s5_nv_reg [3];

    logic                       s6_valid_reg;
    logic [RAD_W-1:0]           s6_rad_reg;
    vrf_side_t                  s6_side_reg;
    logic signed [K_W-1:0]      s6_k_next;

    logic                       sq_valid;
    logic [ROOT_W-1:0]          sq_root;
    logic [ROOT_W+2:0]          sq_rem;
    logic [SIDE_W-1:0]          sq_side_bits;
    vrf_side_t                  sq_side;
    logic [ROOT_W:0]            sq_s_next;

    logic                       s27_valid_reg;
    logic signed [F_W-1:0]      s27_f_reg;
    logic signed [EI_W-1:0]     s27_ei_reg [3];
    logic signed [IN_WIDTH-1:0] s27_nv_reg [3];
    logic                       s27_tir_reg;

    logic                       s28_valid_reg;
    logic signed [37:0]         s28_nf_reg [3];
    logic signed [EI_W-1:0]     s28_ei_reg [3];
    logic                       s28_tir_reg;

    logic signed [V_W-1:0]      v_next [3];
    logic signed [OUT_WIDTH-1:0] c_next [3];
    logic [2:0]                 clip_next;
    vrf_out_t                   res_next;

    logic                       res_valid_reg;
    vrf_out_t                   res_reg;
    logic                       skid_valid_reg;
    vrf_out_t                   skid_reg;
    logic                       arrive;

    assign en        = !skid_valid_reg;
    assign ray_ready = en;

    assign iv[0] = ray.incident_x;
    assign iv[1] = ray.incident_y;
    assign iv[2] = ray.incident_z;
    assign nv[0] = ray.normal_x;
    assign nv[1] = ray.normal_y;
    assign nv[2] = ray.normal_z;
    assign eta   = $signed({1'b0, ray.index_ratio});

    assign s2_d_next = D_W'(rnd(MW'(s1_dp_reg[0]))) + D_W'(rnd(MW'(s1_dp_reg[1])))
                     + D_W'(rnd(MW'(s1_dp_reg[2])));

    assign s6_k_next = K_W'(ONE - rnd(MW'(s5_pk_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s27_valid_reg <= 1'b0;
            s28_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= ray_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s27_valid_reg <= sq_valid;
            s28_valid_reg <= s27_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_dp_reg[i]  <= iv[i] * nv[i];
                s1_ei_reg[i]  <= eta * iv[i];
                s1_nv_reg[i]  <= nv[i];
                s2_ei_reg[i]  <= EI_W'(rnd(MW'(s1_ei_reg[i])));
                s2_nv_reg[i]  <= s1_nv_reg[i];
                s3_ei_reg[i]  <= s2_ei_reg[i];
                s3_nv_reg[i]  <= s2_nv_reg[i];
                s4_ei_reg[i]  <= s3_ei_reg[i];
                s4_nv_reg[i]  <= s3_nv_reg[i];
                s5_ei_reg[i]  <= s4_ei_reg[i];
                s5_nv_reg[i]  <= s4_nv_reg[i];
                s28_nf_reg[i] <= s27_nv_reg[i] * s27_f_reg;
                s28_ei_reg[i] <= s27_ei_reg[i];
            end
            s1_e2_reg  <= eta * eta;
            s1_eta_reg <= eta;

            s2_d_reg   <= s2_d_next;
            s2_e2_reg  <= E2_W'(rnd(MW'(s1_e2_reg)));
            s2_eta_reg <= s1_eta_reg;

            s3_dd_reg  <= s2_d_reg * s2_d_reg;
            s3_ed_reg  <= s2_eta_reg * s2_d_reg;
            s3_e2_reg  <= s2_e2_reg;

            s4_om_reg  <= OM_W'(ONE - rnd(MW'(s3_dd_reg)));
            s4_ed_reg  <= ED_W'(rnd(MW'(s3_ed_reg)));
            s4_e2_reg  <= s3_e2_reg;

            s5_pk_reg  <= s4_e2_reg * s4_om_reg;
            s5_ed_reg  <= s4_ed_reg;

            s6_rad_reg       <= s6_k_next[K_W-1] ? '0
                              : {s6_k_next[RAD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            s6_side_reg.ed   <= s5_ed_reg;
            s6_side_reg.ei_x <= s5_ei_reg[0];
            s6_side_reg.ei_y <= s5_ei_reg[1];
            s6_side_reg.ei_z <= s5_ei_reg[2];
            s6_side_reg.nv_x <= s5_nv_reg[0];
            s6_side_reg.nv_y <= s5_nv_reg[1];
            s6_side_reg.nv_z <= s5_nv_reg[2];
            s6_side_reg.tir  <= s6_k_next[K_W-1];

            s27_f_reg      <= F_W'(sq_side.ed) + F_W'(sq_s_next);
            s27_ei_reg[0]  <= sq_side.ei_x;
            s27_ei_reg[1]  <= sq_side.ei_y;
            s27_ei_reg[2]  <= sq_side.ei_z;
            s27_nv_reg[0]  <= sq_side.nv_x;
            s27_nv_reg[1]  <= sq_side.nv_y;
            s27_nv_reg[2]  <= sq_side.nv_z;
            s27_tir_reg    <= sq_side.tir;

            s28_tir_reg    <= s27_tir_reg;
        end
    end

    vrf_sqrt #(
        .RAD_W  (RAD_W),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_valid_reg),
        .radicand  (s6_rad_reg),
        .in_side   (s6_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .remainder (sq_rem),
        .out_side  (sq_side_bits)
    );

    assign sq_side   = sq_side_bits;
    // Round the floor root up when the remainder exceeds the root.
    assign sq_s_next = (ROOT_W+1)'(sq_root)
                     + (ROOT_W+1)'(sq_rem > (ROOT_W+3)'(sq_root));

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v_next[i]    = V_W'(s28_ei_reg[i]) - V_W'(rnd(MW'(s28_nf_reg[i])));
            clip_next[i] = (v_next[i] > V_MAX) || (v_next[i] < V_MIN);
            if (v_next[i] > V_MAX)
            begin
                c_next[i] = OUT_MAX;
            end
            else if (v_next[i] < V_MIN)
            begin
                c_next[i] = OUT_MIN;
            end
            else
            begin
                c_next[i] = OUT_WIDTH'(v_next[i]);
            end
        end
        if (s28_tir_reg)
        begin
            res_next.refracted_x      = '0;
            res_next.refracted_y      = '0;
            res_next.refracted_z      = '0;
            res_next.total_reflection = 1'b1;
            res_next.saturated        = 1'b0;
        end
        else
        begin
            res_next.refracted_x      = c_next[0];
            res_next.refracted_y      = c_next[1];
            res_next.refracted_z      = c_next[2];
            res_next.total_reflection = 1'b0;
            res_next.saturated        = |clip_next;
        end
    end

    assign arrive = s28_valid_reg && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (res_valid_reg && !res_ready)
        begin
            if (arrive)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            res_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= arrive;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid_reg && !res_ready)
        begin
            if (arrive)
            begin
                skid_reg <= res_next;
            end
        end
        else if (skid_valid_reg)
        begin
            res_reg <= skid_reg;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.total_reflection |-> res.refracted_x == '0
            && res.refracted_y == '0 && res.refracted_z == '0 && !res.saturated)
        else $error("total reflection word carries a nonzero vector or clip flag");

    a_sat_edge: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.saturated |-> res.refracted_x == OUT_MAX
            || res.refracted_x == OUT_MIN || res.refracted_y == OUT_MAX
            || res.refracted_y == OUT_MIN || res.refracted_z == OUT_MAX
            || res.refracted_z == OUT_MIN)
        else $error("clip flag set with no component at a limit");

    a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> res_valid_reg)
        else $error("skid register holds a word while the output is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(res_valid_reg && !res_ready && s28_valid_reg))
        else $error("skid register filled without a stalled output");

endmodule

[design/vrf_sqrt.sv]
module vrf_sqrt #(
    parameter int RAD_W  = 40,
    parameter int SIDE_W = 124
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [RAD_W-1:0]     radicand,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [RAD_W/2-1:0]   root,
    output logic [RAD_W/2+2:0]   remainder,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int N  = RAD_W / 2;
    localparam int RW = N + 3;

    logic          valid_reg [N];
    logic [RW-1:0] rem_reg   [N];
    logic [N-1:0]  q_reg     [N];
    logic [RAD_W-1:0] x_reg  [N];
    logic [SIDE_W-1:0] side_reg [N];

    for (genvar j = 0; j < N; j++) begin : g_stage
        logic          v_in;
        logic [RW-1:0] rem_in;
        logic [N-1:0]  q_in;
        logic [RAD_W-1:0] x_in;
        logic [SIDE_W-1:0] side_in;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic          ge;
        logic [RW-1:0] rem_next;
        logic [N-1:0]  q_next;

        if (j == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign q_in    = '0;
            assign x_in    = radicand;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = valid_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign x_in    = x_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        assign rem_sh   = {rem_in[RW-3:0], x_in[RAD_W-1:RAD_W-2]};
        assign trial    = RW'({q_in, 2'b01});
        assign ge       = rem_sh >= trial;
        assign rem_next = ge ? rem_sh - trial : rem_sh;
        assign q_next   = {q_in[N-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                q_reg[j]    <= q_next;
                x_reg[j]    <= x_in << 2;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign root      = q_reg[N-1];
    assign remainder = rem_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule
